### rtl/core/int_alu_parity_prime_core_macros.svh
// Assertion macros shared by the integer ALU core files.
`ifndef INT_ALU_PARITY_PRIME_CORE_MACROS_SVH
`define INT_ALU_PARITY_PRIME_CORE_MACROS_SVH
`ifndef SYNTH
`define IAP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define IAP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define IAP_ASSERT_NOW(label, ante, cons)
`define IAP_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### rtl/core/iap_pkg.sv
// Package with types, codes and constants of the integer ALU core.
package iap_pkg;

  localparam int DATA_W = 32;
  localparam int CNT_W  = $clog2(DATA_W);

  localparam logic [DATA_W-1:0] INT_MAX = {1'b0, {(DATA_W-1){1'b1}}};

  localparam logic [1:0] FUNC_ARITH  = 2'd0;
  localparam logic [1:0] FUNC_PARITY = 2'd1;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;

  typedef struct packed {
    logic [1:0]               func;
    logic [2:0]               op_code;
    logic signed [DATA_W-1:0] operand_a;
    logic signed [DATA_W-1:0] operand_b;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result;
    logic                     invalid_op;
  } out_t;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quotient;
    logic [DATA_W-1:0] remainder;
  } div_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_PRIME,
    ST_LOAD
  } state_t;

endpackage

### rtl/core/int_alu_parity_prime_core.sv
// Integer ALU with parity and trial-division primality test over one shared serial divider.
// Add, subtract, multiply and parity pass through the EXEC and LOAD states from input beat to result beat.
// Division waits in the DIV state for the divider, which resolves one quotient bit per cycle.
// A primality test runs one divider pass per trial divisor, up to sqrt(n) trials.
// One request is in flight at a time; the next beat is taken once the result is queued.
// Reset is synchronous and active low; it clears the sequencer and the last result to zero.
`include "int_alu_parity_prime_core_macros.svh"

module int_alu_parity_prime_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  iap_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output iap_pkg::out_t out_data
);

  localparam int W = iap_pkg::DATA_W;

  iap_pkg::state_t   state_r, state_nxt;
  iap_pkg::in_t      req_r;
  iap_pkg::out_t     out_data_r;
  iap_pkg::div_req_t div_req;
  iap_pkg::div_rsp_t div_rsp;
  logic              out_valid_r;
  logic [W-1:0]      res_r, res_nxt;
  logic              inv_r, inv_nxt;
  logic [W-1:0]      i_r, i_nxt;
  logic [W-1:0]      last_result_r;
  logic [W-1:0]      mag_a, mag_b, prod;
  logic              exec_div, exec_prime, prime_stop, load_out;

  iap_divider u_divider (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_comb begin
    mag_a      = req_r.operand_a[W-1] ? (~req_r.operand_a + 1'b1) : req_r.operand_a;
    mag_b      = req_r.operand_b[W-1] ? (~req_r.operand_b + 1'b1) : req_r.operand_b;
    prod       = req_r.operand_a * req_r.operand_b;
    exec_div   = (req_r.func == iap_pkg::FUNC_ARITH) && (req_r.op_code == iap_pkg::OP_DIV)
                 && (req_r.operand_b != '0);
    exec_prime = (req_r.func != iap_pkg::FUNC_ARITH) && (req_r.func != iap_pkg::FUNC_PARITY)
                 && !req_r.operand_a[W-1] && (req_r.operand_a[W-1:1] != '0);
    prime_stop = div_rsp.done
                 && ((i_r > div_rsp.quotient) || (div_rsp.remainder == '0));
    load_out   = (state_r == iap_pkg::ST_LOAD) && (!out_valid_r || out_ready);
  end

  always_comb begin
    res_nxt = res_r;
    inv_nxt = inv_r;
    i_nxt   = i_r;
    unique case (state_r)
      iap_pkg::ST_EXEC: begin
        inv_nxt = 1'b0;
        i_nxt   = W'(2);
        case (req_r.func)
          iap_pkg::FUNC_ARITH: begin
            case (req_r.op_code)
              iap_pkg::OP_ADD: res_nxt = req_r.operand_a + req_r.operand_b;
              iap_pkg::OP_SUB: res_nxt = req_r.operand_a - req_r.operand_b;
              iap_pkg::OP_MUL: res_nxt = prod;
              iap_pkg::OP_DIV: res_nxt = iap_pkg::INT_MAX;
              default: begin
                res_nxt = last_result_r;
                inv_nxt = 1'b1;
              end
            endcase
          end
          iap_pkg::FUNC_PARITY: res_nxt = W'(!req_r.operand_a[0]);
          default:              res_nxt = '0;
        endcase
      end
      iap_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          res_nxt = (req_r.operand_a[W-1] ^ req_r.operand_b[W-1])
                    ? (~div_rsp.quotient + 1'b1) : div_rsp.quotient;
        end
      end
      iap_pkg::ST_PRIME: begin
        if (div_rsp.done) begin
          if (i_r > div_rsp.quotient) begin
            res_nxt = W'(1);
          end else if (div_rsp.remainder == '0) begin
            res_nxt = '0;
          end else begin
            i_nxt = i_r + 1'b1;
          end
        end
      end
      default: begin
        res_nxt = res_r;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      iap_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = iap_pkg::ST_EXEC;
      end
      iap_pkg::ST_EXEC: begin
        if (exec_div) begin
          state_nxt = iap_pkg::ST_DIV;
        end else if (exec_prime) begin
          state_nxt = iap_pkg::ST_PRIME;
        end else begin
          state_nxt = iap_pkg::ST_LOAD;
        end
      end
      iap_pkg::ST_DIV: begin
        if (div_rsp.done) state_nxt = iap_pkg::ST_LOAD;
      end
      iap_pkg::ST_PRIME: begin
        if (prime_stop) state_nxt = iap_pkg::ST_LOAD;
      end
      iap_pkg::ST_LOAD: begin
        if (load_out) state_nxt = iap_pkg::ST_IDLE;
      end
      default: state_nxt = iap_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready         = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = mag_a;
    div_req.divisor  = mag_b;
    unique case (state_r)
      iap_pkg::ST_IDLE: in_ready = 1'b1;
      iap_pkg::ST_EXEC: begin
        if (exec_div) begin
          div_req.start = 1'b1;
        end else if (exec_prime) begin
          div_req.start   = 1'b1;
          div_req.divisor = W'(2);
        end
      end
      iap_pkg::ST_PRIME: begin
        div_req.start   = div_rsp.done && !prime_stop;
        div_req.divisor = i_r + 1'b1;
      end
      default: in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= iap_pkg::ST_IDLE;
      out_valid_r   <= 1'b0;
      last_result_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
        if (!inv_r) last_result_r <= res_r;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (in_valid && in_ready) req_r <= in_data;
    res_r <= res_nxt;
    inv_r <= inv_nxt;
    i_r   <= i_nxt;
    if (load_out) begin
      out_data_r.result     <= res_r;
      out_data_r.invalid_op <= inv_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `IAP_ASSERT_NEXT(a_accept_exec, in_valid && in_ready, state_r == iap_pkg::ST_EXEC)
  `IAP_ASSERT_NOW(a_invalid_repeats, load_out && inv_r, res_r == last_result_r)
  `IAP_ASSERT_NOW(a_div_owner, div_rsp.done, state_r == iap_pkg::ST_DIV || state_r == iap_pkg::ST_PRIME)
  `IAP_ASSERT_NEXT(a_load_valid, load_out, out_valid_r && state_r == iap_pkg::ST_IDLE)

endmodule

### rtl/core/iap_divider.sv
// Unsigned restoring divider that produces one quotient bit per cycle.
`include "int_alu_parity_prime_core_macros.svh"

module iap_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  iap_pkg::div_req_t req,
  output iap_pkg::div_rsp_t rsp
);

  localparam int W = iap_pkg::DATA_W;

  logic                         busy_r, busy_nxt;
  logic                         done_r, done_nxt;
  logic [iap_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [W-1:0]                 rem_r, rem_nxt;
  logic [W-1:0]                 quo_r, quo_nxt;
  logic [W-1:0]                 dvsr_r, dvsr_nxt;
  logic [W:0]                   shifted;
  logic [W+1:0]                 diff;

  always_comb begin
    shifted  = {rem_r, quo_r[W-1]};
    diff     = {1'b0, shifted} - {2'b00, dvsr_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvsr_nxt = dvsr_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dvsr_nxt = req.divisor;
    end else if (busy_r) begin
      if (!diff[W+1]) begin
        rem_nxt = diff[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == iap_pkg::CNT_W'(W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    dvsr_r <= dvsr_nxt;
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

  `IAP_ASSERT_NOW(a_start_when_free, req.start, !busy_r)
  `IAP_ASSERT_NOW(a_done_not_busy, done_r, !busy_r)
  `IAP_ASSERT_NEXT(a_start_busy, req.start, busy_r && !done_r)

endmodule
